/* rtl/lpr_pkg.sv */
// Shared constants and types for the LRU page replacement frame table.
// Used by lpr_victim, lpr_table and the lru_page_replacement top level.
package lpr_pkg;

  localparam int FRAME_COUNT_DEF = 8;
  localparam int PAGE_BITS_DEF   = 16;

  localparam int CFG_W           = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  localparam int AGE_W           = 32;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam int FAULT_W         = 32;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  localparam int FRAME_IDX_W     = 3;

  // Result beat: frame_index then fault_total, padded to whole bytes
  localparam int OUT_FIELDS_W    = FRAME_IDX_W + FAULT_W;
  localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic                   was_hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [FAULT_W-1:0]     fault_total;
  } lpr_result_t;

endpackage

/* rtl/lpr_victim.sv */
// Max-age select over the frame table: a compare tree, ties to the lower index.
// Depends on lpr_pkg for the age width.
module lpr_victim
  import lpr_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic [FRAME_COUNT-1:0][AGE_W-1:0] age_i,
  input  logic [FRAME_COUNT-1:0]            cand_i,
  output logic [IDX_W-1:0]                  idx_o
);

  localparam int LEAVES = 1 << IDX_W;

  logic [AGE_W-1:0] leaf_age  [LEAVES];
  logic             leaf_cand [LEAVES];

  logic [AGE_W-1:0] node_age  [1:2*LEAVES-1];
  logic             node_cand [1:2*LEAVES-1];
  logic [IDX_W-1:0] node_idx  [1:2*LEAVES-1];

  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < FRAME_COUNT) begin : g_used
      assign leaf_age[g]  = age_i[g];
      assign leaf_cand[g] = cand_i[g];
    end else begin : g_pad
      assign leaf_age[g]  = '0;
      assign leaf_cand[g] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_age[LEAVES+i]  = leaf_age[i];
      node_cand[LEAVES+i] = leaf_cand[i];
      node_idx[LEAVES+i]  = IDX_W'(i);
    end
    // Left child wins ties, so the lower frame index wins
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (!node_cand[2*i] ||
          (node_cand[2*i+1] && (node_age[2*i+1] > node_age[2*i]))) begin
        node_age[i]  = node_age[2*i+1];
        node_cand[i] = node_cand[2*i+1];
        node_idx[i]  = node_idx[2*i+1];
      end else begin
        node_age[i]  = node_age[2*i];
        node_cand[i] = node_cand[2*i];
        node_idx[i]  = node_idx[2*i];
      end
    end
  end

  assign idx_o = node_idx[1];

endmodule

/* rtl/lpr_table.sv */
// Frame table state (pages, valid bits, ages, fault count), lookup and update.
// Depends on lpr_pkg and instantiates lpr_victim.
module lpr_table
  import lpr_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 last_i,
  input  logic [CFG_W-1:0]     frames_in_use_i,
  output lpr_result_t          result_o
);

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  logic [PAGE_BITS-1:0]                page_q [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]              valid_q, valid_d;
  logic [FRAME_COUNT-1:0][AGE_W-1:0]   age_q, age_d, aged;
  logic [FAULT_W-1:0]                  fault_q, fault_d, fault_next;

  logic [CFG_W-1:0]       cfg_eff;
  logic [FRAME_COUNT-1:0] act;
  logic                   hit_found, empty_found;
  logic [IDX_W-1:0]       hit_idx, empty_idx, victim_idx, slot;

  assign cfg_eff = (frames_in_use_i == '0) ? CFG_W'(1) : frames_in_use_i;

  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int j = 0; j < FRAME_COUNT; j++) begin
      act[j] = (32'(j) < 32'(cfg_eff));
      if (act[j] && valid_q[j] && (age_q[j] != AGE_MAX)) begin
        aged[j] = age_q[j] + AGE_W'(1);
      end else begin
        aged[j] = age_q[j];
      end
    end
    // Scan downwards so the lowest matching index is left standing
    for (int j = FRAME_COUNT - 1; j >= 0; j--) begin
      if (act[j] && valid_q[j] && (page_q[j] == page_i)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(j);
      end
      if (act[j] && !valid_q[j]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(j);
      end
    end
  end

  // With no empty active frame every active frame is valid
  lpr_victim #(
    .FRAME_COUNT (FRAME_COUNT),
    .IDX_W       (IDX_W)
  ) u_victim (
    .age_i  (aged),
    .cand_i (act),
    .idx_o  (victim_idx)
  );

  always_comb begin
    if (hit_found) begin
      slot = hit_idx;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end

    if (hit_found || (fault_q == FAULT_MAX)) begin
      fault_next = fault_q;
    end else begin
      fault_next = fault_q + FAULT_W'(1);
    end

    result_o.was_hit     = hit_found;
    result_o.frame_index = FRAME_IDX_W'(slot);
    result_o.fault_total = fault_next;

    valid_d = valid_q;
    age_d   = age_q;
    fault_d = fault_q;
    if (req_i) begin
      if (last_i) begin
        valid_d = '0;
        age_d   = '0;
        fault_d = '0;
      end else begin
        age_d       = aged;
        age_d[slot] = '0;
        valid_d[slot] = 1'b1;
        fault_d     = fault_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
      fault_q <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      fault_q <= fault_d;
    end
  end

  // Page tags need no reset: a tag is only compared once its valid bit is set
  always_ff @(posedge clk_i) begin
    if (req_i && !hit_found) begin
      page_q[slot] <= page_i;
    end
  end

endmodule

/* rtl/lru_page_replacement.sv */
// LRU page replacement block: input register, frame table, result register.
// Depends on lpr_pkg; instantiates lpr_table.
//
// Usage:
//   Slave stream carries one page reference per beat: tdata holds the page
//   number, tlast marks the last reference of a string. Master stream returns
//   one result per reference: tdata holds frame_index and fault_total, tuser
//   is the hit flag, tlast echoes the end-of-string mark.
//   The active frame count is written through cfg_we_i / cfg_wdata_i while
//   no reference is in flight; zero counts as one frame.
// Pipeline and throughput:
//   A reference is captured in the input register, then looked up and applied
//   to the frame table as it moves into the result register, which presents
//   it on the master side. One reference per cycle is sustained while the
//   receiver holds tready high; the table update is combinational (parallel
//   tag compare plus the max-age compare tree) and sets that figure.
// Reset and stalls:
//   Reset empties the table, clears ages and the fault count and sets the
//   active frame count to eight. While the receiver holds tready low the
//   result register keeps its beat, one further reference waits in the input
//   register, and s_axis_tready drops.
module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  parameter int IN_DATA_W   = ((PAGE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // page_number
  input  logic                  s_axis_tlast,   // end_of_string
  // Master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // frame_index, fault_total
  output logic                  m_axis_tuser,   // was_hit
  output logic                  m_axis_tlast,   // is_last
  // Configuration: frames_in_use
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic                 in_vld_q;
  logic [PAGE_BITS-1:0] in_page_q;
  logic                 in_last_q;
  logic                 out_vld_q;
  lpr_result_t          out_res_q;
  logic                 out_last_q;
  logic [CFG_W-1:0]     cfg_q;
  lpr_result_t          res;
  logic                 advance;
  logic                 in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  lpr_table #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS)
  ) u_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (advance),
    .page_i          (in_page_q),
    .last_i          (in_last_q),
    .frames_in_use_i (cfg_q),
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= CFG_RESET;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_page_q <= s_axis_tdata[PAGE_BITS-1:0];
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_res_q  <= res;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_res_q.fault_total, out_res_q.frame_index});
  assign m_axis_tuser  = out_res_q.was_hit;
  assign m_axis_tlast  = out_last_q;

endmodule

/* test/tb_lru_page_replacement.sv */
// Testbench for the LRU page replacement frame table: stream stimulus, result checking.
// Depends on lpr_pkg and lru_page_replacement; keeps its own model of the frame table.
module tb_lru_page_replacement;

  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  localparam int PAGE_W  = PAGE_BITS_DEF;
  localparam int FRAMES  = FRAME_COUNT_DEF;
  localparam int RANDOM_REFS = 530;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic [FAULT_W-1:0]     faults;
    logic                   last;
  } lookup_t;

  typedef struct {
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_val;
    logic [PAGE_W-1:0] page;
    logic              eos;
    logic              typed;
    lookup_t           want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PAGE_W-1:0]     s_axis_tdata;   // page_number
  logic                  s_axis_tlast;   // end_of_string
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // frame_index, fault_total
  logic                  m_axis_tuser;   // was_hit
  logic                  m_axis_tlast;   // is_last
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  // Frame table as the testbench sees it
  logic [PAGE_W-1:0]  tbl_page [FRAMES];
  logic               tbl_valid [FRAMES];
  logic [AGE_W-1:0]   tbl_age [FRAMES];
  logic [FAULT_W-1:0] tbl_faults;
  logic [CFG_W-1:0]   frames_cfg;

  lookup_t   pending_results [$];
  plan_row_t plan [$];
  int        mismatches;
  bit        src_burst;
  bit        snk_burst;

  lru_page_replacement u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic lookup_t lru_reference(input logic [PAGE_W-1:0] page, input logic eos);
    int n;
    int j;
    int hit_idx;
    int slot;
    logic [AGE_W-1:0] oldest;
    lookup_t r;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    hit_idx = -1;
    slot = -1;
    for (j = 0; j < n; j++)
      if (hit_idx < 0 && tbl_valid[j] && tbl_page[j] == page) hit_idx = j;
    for (j = 0; j < n; j++)
      if (tbl_valid[j] && tbl_age[j] != AGE_MAX) tbl_age[j] = tbl_age[j] + 1'b1;
    if (hit_idx >= 0) begin
      tbl_age[hit_idx] = '0;
      slot = hit_idx;
    end else begin
      for (j = 0; j < n; j++)
        if (slot < 0 && !tbl_valid[j]) slot = j;
      if (slot < 0) begin
        // oldest frame wins, lowest index on a tie
        slot = 0;
        oldest = tbl_age[0];
        for (j = 1; j < n; j++)
          if (tbl_age[j] > oldest) begin
            oldest = tbl_age[j];
            slot = j;
          end
      end
      tbl_page[slot]  = page;
      tbl_valid[slot] = 1'b1;
      tbl_age[slot]   = '0;
      if (tbl_faults != FAULT_MAX) tbl_faults = tbl_faults + 1'b1;
    end
    r.hit    = (hit_idx >= 0);
    r.frame  = FRAME_IDX_W'(slot);
    r.faults = tbl_faults;
    r.last   = eos;
    if (eos) begin
      for (j = 0; j < FRAMES; j++) begin
        tbl_valid[j] = 1'b0;
        tbl_age[j]   = '0;
      end
      tbl_faults = '0;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_reference(input logic [PAGE_W-1:0] page, input logic eos,
                                input logic typed, input lookup_t typed_want);
    int gap;
    lookup_t predicted;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = lru_reference(page, eos);
    pending_results.push_back(typed ? typed_want : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_frames_in_use(input logic [CFG_W-1:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frames_cfg = val;
  endtask

  function automatic void add_row(input logic cfg_we, input logic [CFG_W-1:0] cfg_val,
                                  input logic [PAGE_W-1:0] page, input logic eos,
                                  input logic typed, input lookup_t want);
    plan_row_t row;
    row.cfg_we  = cfg_we;
    row.cfg_val = cfg_val;
    row.page    = page;
    row.eos     = eos;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, hit %0d frame %0d faults %0d last %0d",
                 $time, m_axis_tuser, m_axis_tdata[FRAME_IDX_W-1:0],
                 m_axis_tdata[FRAME_IDX_W +: FAULT_W], m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.hit) begin
          $display("%0t: was_hit expected %0d, got %0d", $time, want.hit, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[FRAME_IDX_W-1:0] !== want.frame) begin
          $display("%0t: frame_index expected %0d, got %0d", $time, want.frame,
                   m_axis_tdata[FRAME_IDX_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[FRAME_IDX_W +: FAULT_W] !== want.faults) begin
          $display("%0t: fault_total expected %0d, got %0d", $time, want.faults,
                   m_axis_tdata[FRAME_IDX_W +: FAULT_W]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: is_last expected %0d, got %0d", $time, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Result receiver: a fresh stall for every beat, none while in burst
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = snk_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("lru_page_replacement verification failed");
    $finish;
  end

  initial begin
    lookup_t none;
    logic [PAGE_W-1:0] pool [12];
    int pool_n;
    int phase_len;
    int sent;
    int k;
    logic [CFG_W-1:0] cfg_pick;
    logic [PAGE_W-1:0] page;
    logic eos;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    src_burst     = 1'b0;
    snk_burst     = 1'b0;
    none          = '0;
    for (k = 0; k < FRAMES; k++) begin
      tbl_page[k]  = '0;
      tbl_valid[k] = 1'b0;
      tbl_age[k]   = '0;
    end
    tbl_faults = '0;
    frames_cfg = CFG_RESET;

    // Directed: fill, hit, eviction, end of string, small and clamped frame counts,
    // inactive frames kept and revived, duplicate resident page
    add_row(0, 0, 16'h0000, 0, 1, '{hit: 0, frame: 0, faults: 1, last: 0});
    add_row(0, 0, 16'hFFFF, 0, 1, '{hit: 0, frame: 1, faults: 2, last: 0});
    add_row(0, 0, 16'h0000, 0, 1, '{hit: 1, frame: 0, faults: 2, last: 0});
    for (k = 1; k <= 6; k++) add_row(0, 0, PAGE_W'(k), 0, 0, none);
    add_row(0, 0, 16'h8000, 0, 0, none);
    add_row(0, 0, 16'h5555, 1, 0, none);
    add_row(0, 0, 16'hAAAA, 0, 1, '{hit: 0, frame: 0, faults: 1, last: 0});
    add_row(1, 1, 16'hAAAA, 0, 0, none);
    add_row(0, 0, 16'h1234, 0, 0, none);
    add_row(1, 0, 16'h1234, 0, 0, none);
    add_row(1, 3, 16'h0007, 0, 0, none);
    add_row(0, 0, 16'h0008, 0, 0, none);
    add_row(1, 15, 16'h0009, 0, 0, none);
    add_row(1, 2, 16'h0009, 0, 0, none);
    add_row(1, 8, 16'h0009, 0, 0, none);
    add_row(0, 0, 16'hFFFF, 1, 0, none);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg_we) write_frames_in_use(plan[i].cfg_val);
      send_reference(plan[i].page, plan[i].eos, plan[i].typed, plan[i].want);
    end

    // Random: phases of references drawn mostly from a small working set
    sent = 0;
    while (sent < RANDOM_REFS) begin
      case ($urandom_range(0, 5))
        0:       cfg_pick = 0;
        1:       cfg_pick = 1;
        2:       cfg_pick = 8;
        3:       cfg_pick = 15;
        default: cfg_pick = CFG_W'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 3) != 0) write_frames_in_use(cfg_pick);
      else drain_results();
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      pool_n = $urandom_range(2, 12);
      for (k = 0; k < 12; k++) pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
      phase_len = $urandom_range(30, 70);
      for (k = 0; k < phase_len && sent < RANDOM_REFS; k++) begin
        if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool_n - 1)];
        else page = PAGE_W'($urandom_range(0, 16'hFFFF));
        eos = ($urandom_range(0, 39) == 0);
        send_reference(page, eos, 1'b0, none);
        sent++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lpr_pkg.sv
rtl/lpr_victim.sv
rtl/lpr_table.sv
rtl/lru_page_replacement.sv
test/tb_lru_page_replacement.sv
